// File: hw/rtl/lrp_pkg.sv
// shared types and constants of the line raster plotter
`timescale 1ns / 1ps

package lrp_pkg;

  // command codes of an input word
  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // configuration register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam int CFG_DATA_W    = 10;
  localparam int COORD_W       = 12;
  localparam int ERR_W         = 14;
  localparam int COUNT_W       = 13;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 13'd4096;
  localparam logic [9:0] WIDTH_RESET  = 10'd512;
  localparam logic [8:0] HEIGHT_RESET = 9'd256;

  typedef struct packed {
    logic [1:0]                 cmd;
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  end_x;
    logic signed [COORD_W-1:0]  end_y;
    logic [11:0]                word_index;
  } in_t;

  typedef struct packed {
    logic [31:0]        read_word;
    logic [COUNT_W-1:0] plotted_count;
  } out_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_QUO,
    ST_REM,
    ST_WR,
    ST_RDWAIT,
    ST_CLEAR,
    ST_DONE
  } state_t;

  // operations of the shared multiplier
  typedef enum logic [1:0] {
    MUL_IDX,
    MUL_QUO,
    MUL_REM
  } mul_op_t;

  // line walker control and status
  typedef struct packed {
    logic load;
    logic step;
  } walk_ctrl_t;

  typedef struct packed {
    logic                      on_canvas;
    logic                      at_end;
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;
  } walk_stat_t;

endpackage

// File: hw/rtl/lrp_store.sv
// dot store: one write port, one registered read port
`timescale 1ns / 1ps

module lrp_store #(
  parameter int WORDS  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] store_mem [WORDS];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/lrp_mul_unit.sv
// shared multiplier: dot index, word quotient by reciprocal, bit remainder
`timescale 1ns / 1ps

module lrp_mul_unit #(
  parameter int IDX_W     = 17,
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  lrp_pkg::mul_op_t      op,
  input  logic [IDX_W-1:0]      opa,
  input  logic [9:0]            opw,
  input  logic [IDX_W-1:0]      opc,
  output logic [IDX_W-1:0]      res
);

  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int SHIFT  = IDX_W + BIT_W;
  localparam int RECIP  = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int RCP_W  = IDX_W + 2;
  localparam int B_W    = (RCP_W > 10) ? RCP_W : 10;
  localparam int PROD_W = IDX_W + B_W;

  logic [B_W-1:0]    opb;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  res_nxt;
  logic [IDX_W-1:0]  res_r;

  // operand select and post-multiply add, subtract or shift
  always_comb begin
    opb     = B_W'(opw);
    res_nxt = '0;
    unique case (op)
      lrp_pkg::MUL_IDX: opb = B_W'(opw);
      lrp_pkg::MUL_QUO: opb = B_W'(RECIP);
      lrp_pkg::MUL_REM: opb = B_W'(WORD_BITS);
      default:          opb = B_W'(opw);
    endcase
    prod = PROD_W'(opa) * PROD_W'(opb);
    unique case (op)
      lrp_pkg::MUL_IDX: res_nxt = IDX_W'(prod + PROD_W'(opc));
      lrp_pkg::MUL_QUO: res_nxt = IDX_W'(prod >> SHIFT);
      lrp_pkg::MUL_REM: res_nxt = IDX_W'(PROD_W'(opc) - prod);
      default:          res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

// File: hw/rtl/lrp_walker.sv
// bresenham walker: current point, error term and clip test
`timescale 1ns / 1ps

module lrp_walker (
  input  logic                clk,
  input  logic                rst_n,
  input  lrp_pkg::walk_ctrl_t ctrl,
  input  lrp_pkg::in_t        in_data,
  input  logic [9:0]          w_eff,
  input  logic [8:0]          h_eff,
  output lrp_pkg::walk_stat_t stat
);

  localparam int CW = lrp_pkg::COORD_W;
  localparam int EW = lrp_pkg::ERR_W;

  logic signed [CW-1:0] cur_x_r, cur_x_nxt;
  logic signed [CW-1:0] cur_y_r, cur_y_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic signed [CW:0]   dx_r, dx_nxt;
  logic signed [CW:0]   dy_r, dy_nxt;
  logic                 sx_neg_r, sx_neg_nxt;
  logic                 sy_neg_r, sy_neg_nxt;
  logic signed [CW-1:0] end_x_r, end_x_nxt;
  logic signed [CW-1:0] end_y_r, end_y_nxt;

  logic signed [CW:0]   diff_x;
  logic signed [CW:0]   diff_y;
  logic signed [EW:0]   e2;
  logic                 mv_x;
  logic                 mv_y;

  // load endpoints or take one step
  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    err_nxt    = err_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    sx_neg_nxt = sx_neg_r;
    sy_neg_nxt = sy_neg_r;
    end_x_nxt  = end_x_r;
    end_y_nxt  = end_y_r;
    diff_x = (CW+1)'(in_data.end_x) - (CW+1)'(in_data.start_x);
    diff_y = (CW+1)'(in_data.end_y) - (CW+1)'(in_data.start_y);
    e2     = {err_r, 1'b0};
    mv_x   = e2 >= (EW+1)'(dy_r);
    mv_y   = e2 <= (EW+1)'(dx_r);
    if (ctrl.load) begin
      cur_x_nxt  = in_data.start_x;
      cur_y_nxt  = in_data.start_y;
      end_x_nxt  = in_data.end_x;
      end_y_nxt  = in_data.end_y;
      dx_nxt     = diff_x[CW] ? -diff_x : diff_x;
      dy_nxt     = diff_y[CW] ? diff_y : -diff_y;
      sx_neg_nxt = !(in_data.start_x < in_data.end_x);
      sy_neg_nxt = !(in_data.start_y < in_data.end_y);
      err_nxt    = EW'(dx_nxt) + EW'(dy_nxt);
    end else if (ctrl.step) begin
      if (mv_x) begin
        cur_x_nxt = sx_neg_r ? cur_x_r - CW'(1) : cur_x_r + CW'(1);
      end
      if (mv_y) begin
        cur_y_nxt = sy_neg_r ? cur_y_r - CW'(1) : cur_y_r + CW'(1);
      end
      err_nxt = err_r + (mv_x ? EW'(dy_r) : EW'(0)) + (mv_y ? EW'(dx_r) : EW'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
      err_r   <= '0;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    sx_neg_r <= sx_neg_nxt;
    sy_neg_r <= sy_neg_nxt;
    end_x_r  <= end_x_nxt;
    end_y_r  <= end_y_nxt;
  end

  // clip test and end detect on the current point
  always_comb begin
    stat.cur_x     = cur_x_r;
    stat.cur_y     = cur_y_r;
    stat.at_end    = (cur_x_r == end_x_r) && (cur_y_r == end_y_r);
    stat.on_canvas = !cur_x_r[CW-1] && (cur_x_r[CW-2:0] < (CW-1)'(w_eff)) &&
                     !cur_y_r[CW-1] && (cur_y_r[CW-2:0] < (CW-1)'(h_eff));
  end

endmodule

// File: hw/rtl/line_raster_plotter.sv
// top level: sequencer, configuration registers and result register
`timescale 1ns / 1ps

// Line rasterizer on a one-bit-per-dot canvas held in a single-port-write,
// registered-read store of ceil(MAX_WIDTH*MAX_HEIGHT/WORD_BITS) words
// (4096 at the defaults). After reset the store is swept to zero, one word
// a cycle, and no word is taken until the sweep ends; a clear
// word takes the same sweep. A draw walks the line one dot per step: a dot
// off the canvas is only stepped past, while for a dot on the canvas one
// shared multiplier forms the dot index, the store word by reciprocal and
// the bit within the word, followed by the read-modify-write of that word.
// One word is worked at a time; the result register lets the next word
// enter while a result waits. Configuration writes are taken every cycle
// and belong to idle periods.
module line_raster_plotter #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 256,
  parameter int WORD_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lrp_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lrp_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [lrp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int EFF_W_MAX   = (MAX_WIDTH < 1023) ? MAX_WIDTH : 1023;
  localparam int EFF_H_MAX   = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
  localparam int STORE_WORDS = (MAX_WIDTH * MAX_HEIGHT + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W      = $clog2(STORE_WORDS);
  localparam int IDX_W       = $clog2(EFF_W_MAX * EFF_H_MAX);
  localparam int BIT_W       = $clog2(WORD_BITS);
  localparam int CNT_W       = lrp_pkg::COUNT_W;

  lrp_pkg::state_t     state_r, state_nxt;
  logic [9:0]          cw_r;
  logic [8:0]          ch_r;
  logic [9:0]          w_eff;
  logic [8:0]          h_eff;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [31:0]         res_word_r, res_word_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [ADDR_W-1:0]   waddr_r, waddr_nxt;
  logic                out_valid_r, out_valid_nxt;
  lrp_pkg::out_t       out_data_r, out_data_nxt;

  lrp_pkg::walk_ctrl_t walk_ctrl;
  lrp_pkg::walk_stat_t walk_stat;
  lrp_pkg::mul_op_t    mul_op;
  logic [IDX_W-1:0]    mul_a;
  logic [IDX_W-1:0]    mul_c;
  logic [IDX_W-1:0]    mul_res;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic [BIT_W-1:0]    bit_sel;
  logic                accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= lrp_pkg::WIDTH_RESET;
      ch_r <= lrp_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lrp_pkg::CFG_WIDTH:  cw_r <= cfg_data;
        lrp_pkg::CFG_HEIGHT: ch_r <= cfg_data[8:0];
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // canvas size clamped to the store geometry
  assign w_eff = (32'(cw_r) > 32'(MAX_WIDTH))  ? 10'(MAX_WIDTH)  : cw_r;
  assign h_eff = (32'(ch_r) > 32'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : ch_r;

  lrp_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (walk_ctrl),
    .in_data (in_data),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .stat    (walk_stat)
  );

  lrp_mul_unit #(
    .IDX_W     (IDX_W),
    .WORD_BITS (WORD_BITS)
  ) u_mul (
    .clk (clk),
    .op  (mul_op),
    .opa (mul_a),
    .opw (w_eff),
    .opc (mul_c),
    .res (mul_res)
  );

  lrp_store #(
    .WORDS  (STORE_WORDS),
    .ADDR_W (ADDR_W),
    .DATA_W (WORD_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept  = in_valid && !in_stall;
  assign bit_sel = BIT_W'(mul_res);

  // sequencer: next state, unit operands, store access
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cnt_nxt       = cnt_r;
    res_word_nxt  = res_word_r;
    idx_nxt       = idx_r;
    waddr_nxt     = waddr_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    walk_ctrl     = '0;
    mul_op        = lrp_pkg::MUL_IDX;
    mul_a         = IDX_W'(walk_stat.cur_y[10:0]);
    mul_c         = IDX_W'(walk_stat.cur_x[10:0]);
    wr_en         = 1'b0;
    wr_addr       = waddr_r;
    wr_data       = rd_data | (WORD_BITS'(1) << bit_sel);
    rd_en         = 1'b0;
    rd_addr       = ADDR_W'(mul_res);
    in_stall      = (state_r != lrp_pkg::ST_IDLE);
    unique case (state_r)
      lrp_pkg::ST_INIT, lrp_pkg::ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(STORE_WORDS - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = (state_r == lrp_pkg::ST_INIT) ? lrp_pkg::ST_IDLE
                                                       : lrp_pkg::ST_DONE;
        end
      end
      lrp_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_nxt      = '0;
          res_word_nxt = '0;
          unique case (in_data.cmd)
            lrp_pkg::CMD_DRAW: begin
              walk_ctrl.load = 1'b1;
              state_nxt      = lrp_pkg::ST_WALK;
            end
            lrp_pkg::CMD_CLEAR: begin
              state_nxt = lrp_pkg::ST_CLEAR;
            end
            lrp_pkg::CMD_READ: begin
              rd_addr = ADDR_W'(in_data.word_index);
              if (32'(in_data.word_index) < 32'(STORE_WORDS)) begin
                rd_en     = 1'b1;
                state_nxt = lrp_pkg::ST_RDWAIT;
              end else begin
                state_nxt = lrp_pkg::ST_DONE;
              end
            end
            default: begin
              state_nxt = lrp_pkg::ST_DONE;
            end
          endcase
        end
      end
      lrp_pkg::ST_WALK: begin
        // index y*w+x goes into the multiplier while the clip test runs
        if (walk_stat.on_canvas) begin
          if (cnt_r < lrp_pkg::COUNT_LIMIT) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          state_nxt = lrp_pkg::ST_QUO;
        end else if (walk_stat.at_end) begin
          state_nxt = lrp_pkg::ST_DONE;
        end else begin
          walk_ctrl.step = 1'b1;
        end
      end
      lrp_pkg::ST_QUO: begin
        mul_op    = lrp_pkg::MUL_QUO;
        mul_a     = mul_res;
        idx_nxt   = mul_res;
        state_nxt = lrp_pkg::ST_REM;
      end
      lrp_pkg::ST_REM: begin
        // word address is ready: fetch it, find the bit within it
        mul_op    = lrp_pkg::MUL_REM;
        mul_a     = mul_res;
        mul_c     = idx_r;
        rd_en     = 1'b1;
        waddr_nxt = ADDR_W'(mul_res);
        state_nxt = lrp_pkg::ST_WR;
      end
      lrp_pkg::ST_WR: begin
        wr_en = 1'b1;
        if (walk_stat.at_end) begin
          state_nxt = lrp_pkg::ST_DONE;
        end else begin
          walk_ctrl.step = 1'b1;
          state_nxt      = lrp_pkg::ST_WALK;
        end
      end
      lrp_pkg::ST_RDWAIT: begin
        res_word_nxt = 32'(rd_data);
        state_nxt    = lrp_pkg::ST_DONE;
      end
      lrp_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.read_word     = res_word_r;
          out_data_nxt.plotted_count = cnt_r;
          out_valid_nxt              = 1'b1;
          state_nxt                  = lrp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lrp_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrp_pkg::ST_INIT;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_word_r <= res_word_nxt;
    idx_r      <= idx_nxt;
    waddr_r    <= waddr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a new result only comes out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lrp_pkg::ST_DONE))
    else $error("result word raised outside the done state");

  // the quotient step always follows an index step of the walk
  a_quo_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lrp_pkg::ST_QUO) |-> $past(state_r == lrp_pkg::ST_WALK))
    else $error("quotient step without index step");

  // the dot count saturates
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lrp_pkg::COUNT_LIMIT)
    else $error("plotted count above limit");

  // a plotted word lies inside the store
  a_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lrp_pkg::ST_WR) |-> (32'(waddr_r) < 32'(STORE_WORDS)))
    else $error("plot address beyond store");

  // no store write while an item may enter
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !wr_en)
    else $error("store written while idle");

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for the line raster plotter: canvas model, directed and random words
`timescale 1ns / 1ps

module tb;

  localparam int MAX_WIDTH    = 512;
  localparam int MAX_HEIGHT   = 256;
  localparam int WORD_BITS    = 32;
  localparam int STORE_WORDS  = (MAX_WIDTH * MAX_HEIGHT + WORD_BITS - 1) / WORD_BITS;
  localparam int RANDOM_WORDS = 520;
  localparam int PHASES       = 8;
  localparam int LONG_HOLD    = 400;
  localparam int REPORT_LIMIT = 10;
  localparam int DIR_ROWS     = 23;
  localparam int CW           = lrp_pkg::COORD_W;
  localparam int CNTW         = lrp_pkg::COUNT_W;

  typedef struct {
    lrp_pkg::in_t  stim;
    bit            known;
    lrp_pkg::out_t result;
  } dir_row_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  lrp_pkg::in_t                   in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  lrp_pkg::out_t                  out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic                           cfg_index = lrp_pkg::CFG_WIDTH;
  logic [lrp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // canvas model state
  logic [31:0]   canvas_words [STORE_WORDS];
  logic [9:0]    width_reg;
  logic [8:0]    height_reg;
  int            pen_x, pen_y, pen_err;
  lrp_pkg::out_t pending_results [$];

  dir_row_t directed_rows [DIR_ROWS];
  int phase_width  [PHASES] = '{512, 37, 1, 1023, 0, 512, 100, 16};
  int phase_height [PHASES] = '{256, 100, 1, 511, 256, 0, 17, 256};

  int            sender_idle_pct   = 0;
  int            receiver_idle_pct = 0;
  bit            hold_active       = 1'b0;
  int            hold_count        = 0;
  int            fail_count        = 0;
  int            results_checked   = 0;
  int            cfg_writes        = 0;
  int            cmd_count [4]     = '{0, 0, 0, 0};
  longint        cycles            = 0;
  longint        cycle_limit       = 4 * STORE_WORDS + 4 * LONG_HOLD + 20000;
  lrp_pkg::out_t oldest;

  always #4 clk = ~clk;

  line_raster_plotter #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .WORD_BITS (WORD_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // canvas model: walks a draw, clears the canvas or reads one store word
  task automatic plot_word(input lrp_pkg::in_t w, output lrp_pkg::out_t r);
    int wid, hgt, x1, y1, dx, dy, sx, sy, e2, idx;
    int unsigned cnt;
    bit done;
    wid  = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    hgt  = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    r    = '0;
    cnt  = 0;
    done = 1'b0;
    case (w.cmd)
      lrp_pkg::CMD_DRAW: begin
        pen_x = $signed(w.start_x);
        pen_y = $signed(w.start_y);
        x1    = $signed(w.end_x);
        y1    = $signed(w.end_y);
        dx    = (x1 > pen_x) ? x1 - pen_x : pen_x - x1;
        dy    = (y1 > pen_y) ? pen_y - y1 : y1 - pen_y;
        sx    = (pen_x < x1) ? 1 : -1;
        sy    = (pen_y < y1) ? 1 : -1;
        pen_err = dx + dy;
        while (!done) begin
          // set the dot if it lies on the canvas
          if (pen_x >= 0 && pen_x < wid && pen_y >= 0 && pen_y < hgt) begin
            idx = pen_y * wid + pen_x;
            canvas_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
            if (cnt < lrp_pkg::COUNT_LIMIT) cnt++;
          end
          if (pen_x == x1 && pen_y == y1) begin
            done = 1'b1;
          end else begin
            e2 = 2 * pen_err;
            if (e2 >= dy) begin
              pen_err += dy;
              pen_x   += sx;
            end
            if (e2 <= dx) begin
              pen_err += dx;
              pen_y   += sy;
            end
          end
        end
        r.plotted_count = cnt[CNTW-1:0];
      end
      lrp_pkg::CMD_CLEAR: begin
        foreach (canvas_words[i]) canvas_words[i] = '0;
      end
      lrp_pkg::CMD_READ: begin
        if (w.word_index < STORE_WORDS) r.read_word = canvas_words[w.word_index];
      end
      default: ;
    endcase
  endtask

  // upper bound on the cycles the block spends on one word
  function automatic int work_cycles(lrp_pkg::in_t w);
    int ax, ay;
    ax = $signed(w.end_x) - $signed(w.start_x);
    ay = $signed(w.end_y) - $signed(w.start_y);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    case (w.cmd)
      lrp_pkg::CMD_DRAW:  return 4 * ((ax > ay) ? ax + 1 : ay + 1) + 8;
      lrp_pkg::CMD_CLEAR: return STORE_WORDS + 16;
      default:            return 8;
    endcase
  endfunction

  function automatic dir_row_t make_row(logic [1:0] c, int sx, int sy, int ex, int ey,
                                        int wi, bit known, logic [31:0] rw, int cnt);
    dir_row_t d;
    d.stim.cmd                = c;
    d.stim.start_x            = CW'(sx);
    d.stim.start_y            = CW'(sy);
    d.stim.end_x              = CW'(ex);
    d.stim.end_y              = CW'(ey);
    d.stim.word_index         = 12'(wi);
    d.known                   = known;
    d.result.read_word        = rw;
    d.result.plotted_count    = CNTW'(cnt);
    return d;
  endfunction

  // random word shaped around the current canvas size
  function automatic lrp_pkg::in_t random_word();
    lrp_pkg::in_t w;
    int wid, hgt, r, x0, y0, used;
    wid          = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    hgt          = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    w.cmd        = lrp_pkg::CMD_DRAW;
    w.start_x    = CW'($urandom_range(4095));
    w.start_y    = CW'($urandom_range(4095));
    w.end_x      = CW'($urandom_range(4095));
    w.end_y      = CW'($urandom_range(4095));
    w.word_index = 12'($urandom_range(4095));
    r            = int'($urandom_range(99));
    if (r < 60) begin
      // short line near or across the canvas
      x0        = int'($urandom_range(wid + 15)) - 8;
      y0        = int'($urandom_range(hgt + 15)) - 8;
      w.start_x = CW'(x0);
      w.start_y = CW'(y0);
      w.end_x   = CW'(x0 + int'($urandom_range(48)) - 24);
      w.end_y   = CW'(y0 + int'($urandom_range(48)) - 24);
    end else if (r < 63) begin
      // long line with endpoints anywhere in the coordinate range
      w.cmd = lrp_pkg::CMD_DRAW;
    end else if (r < 92) begin
      w.cmd = lrp_pkg::CMD_READ;
      used  = (wid * hgt + WORD_BITS - 1) / WORD_BITS;
      if ($urandom_range(9) != 0) w.word_index = 12'($urandom_range(used + 1));
    end else if (r < 94) begin
      w.cmd = lrp_pkg::CMD_CLEAR;
    end else begin
      w.cmd = lrp_pkg::CMD_NONE;
    end
    return w;
  endfunction

  // offer one word, wait until the block takes it, then queue its result
  task automatic send_word(input lrp_pkg::in_t w, input bit known, input lrp_pkg::out_t typed);
    lrp_pkg::out_t r;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    plot_word(w, r);
    if (known) r = typed;
    pending_results.push_back(r);
    cycle_limit += 4 * work_cycles(w) + 256;
    cmd_count[w.cmd]++;
  endtask

  // drop valid and wait until every result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[lrp_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == lrp_pkg::CFG_WIDTH) width_reg = value[9:0];
    else height_reg = value[8:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // receiver stall: long hold-off when asked, else random
  always @(negedge clk) begin
    if (hold_active) begin
      out_stall <= 1'b1;
      hold_count++;
      if (hold_count >= LONG_HOLD) hold_active = 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: read_word %h plotted_count %0d",
                   out_data.read_word, out_data.plotted_count);
      end else begin
        oldest = pending_results.pop_front();
        results_checked++;
        if (out_data.read_word !== oldest.read_word ||
            out_data.plotted_count !== oldest.plotted_count) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch on result %0d: expected %h/%0d, got %h/%0d",
                     results_checked, oldest.read_word, oldest.plotted_count,
                     out_data.read_word, out_data.plotted_count);
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycles <= cycle_limit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    lrp_pkg::in_t w;
    int           n;
    foreach (canvas_words[i]) canvas_words[i] = '0;
    width_reg  = lrp_pkg::WIDTH_RESET;
    height_reg = lrp_pkg::HEIGHT_RESET;
    pen_x      = 0;
    pen_y      = 0;
    pen_err    = 0;

    // directed words on the reset canvas of 512 x 256
    directed_rows[0]  = make_row(lrp_pkg::CMD_READ, 0, 0, 0, 0, 0, 1, 32'h0, 0);
    directed_rows[1]  = make_row(lrp_pkg::CMD_READ, 0, 0, 0, 0, 4095, 1, 32'h0, 0);
    directed_rows[2]  = make_row(lrp_pkg::CMD_NONE, -1, -1, -1, -1, 4095, 1, 32'h0, 0);
    directed_rows[3]  = make_row(lrp_pkg::CMD_DRAW, 5, 5, 5, 5, 0, 1, 32'h0, 1);
    directed_rows[4]  = make_row(lrp_pkg::CMD_DRAW, 0, 0, 31, 0, 0, 1, 32'h0, 32);
    directed_rows[5]  = make_row(lrp_pkg::CMD_READ, 0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF, 0);
    directed_rows[6]  = make_row(lrp_pkg::CMD_DRAW, 511, 0, 511, 255, 0, 1, 32'h0, 256);
    directed_rows[7]  = make_row(lrp_pkg::CMD_READ, 0, 0, 0, 0, 4095, 1, 32'h8000_0000, 0);
    directed_rows[8]  = make_row(lrp_pkg::CMD_DRAW, -2048, -2048, 2047, 2047, 0, 1,
                                 32'h0, 256);
    directed_rows[9]  = make_row(lrp_pkg::CMD_DRAW, 2047, -2048, -2048, 2047, 0, 1,
                                 32'h0, 0);
    directed_rows[10] = make_row(lrp_pkg::CMD_DRAW, -100, -100, -10, -50, 0, 1, 32'h0, 0);
    directed_rows[11] = make_row(lrp_pkg::CMD_DRAW, 10, 3, 3, 40, 2730, 0, 32'h0, 0);
    directed_rows[12] = make_row(lrp_pkg::CMD_DRAW, 100, 200, 60, 190, 1365, 0, 32'h0, 0);
    directed_rows[13] = make_row(lrp_pkg::CMD_DRAW, -5, 10, 20, 12, 0, 0, 32'h0, 0);
    directed_rows[14] = make_row(lrp_pkg::CMD_DRAW, 600, 300, 400, 100, 0, 0, 32'h0, 0);
    directed_rows[15] = make_row(lrp_pkg::CMD_READ, 1, 2, 3, 4, 48, 0, 32'h0, 0);
    directed_rows[16] = make_row(lrp_pkg::CMD_READ, 0, 0, 0, 0, 80, 0, 32'h0, 0);
    directed_rows[17] = make_row(lrp_pkg::CMD_READ, 0, 0, 0, 0, 3203, 0, 32'h0, 0);
    directed_rows[18] = make_row(lrp_pkg::CMD_CLEAR, 7, -7, 2047, -2048, 123, 1, 32'h0, 0);
    directed_rows[19] = make_row(lrp_pkg::CMD_READ, 0, 0, 0, 0, 0, 1, 32'h0, 0);
    directed_rows[20] = make_row(lrp_pkg::CMD_READ, 0, 0, 0, 0, 4095, 1, 32'h0, 0);
    directed_rows[21] = make_row(lrp_pkg::CMD_DRAW, 0, 255, 511, 0, 0, 0, 32'h0, 0);
    directed_rows[22] = make_row(lrp_pkg::CMD_READ, 0, 0, 0, 0, 4080, 0, 32'h0, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].stim, directed_rows[i].known, directed_rows[i].result);
    drain();

    // receiver holds off while words keep coming, so the input backs up
    hold_count  = 0;
    hold_active = 1'b1;
    for (int k = 0; k < 8; k++) begin
      w = random_word();
      if (w.cmd == lrp_pkg::CMD_CLEAR) w.cmd = lrp_pkg::CMD_READ;
      send_word(w, 1'b0, '0);
    end
    cycle_limit += 4 * LONG_HOLD;
    drain();

    // random phases, each on its own canvas size
    for (int p = 0; p < PHASES; p++) begin
      write_reg(lrp_pkg::CFG_WIDTH, phase_width[p]);
      write_reg(lrp_pkg::CFG_HEIGHT, phase_height[p]);
      if (p < 3) begin
        sender_idle_pct   = 33;
        receiver_idle_pct = 81;
      end else if (p < 6) begin
        sender_idle_pct   = 81;
        receiver_idle_pct = 33;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      n = 0;
      while (n < RANDOM_WORDS / PHASES) begin
        w = random_word();
        send_word(w, 1'b0, '0);
        if (w.cmd != lrp_pkg::CMD_NONE) n++;
      end
      drain();
    end

    repeat (16) @(posedge clk);
    $display("ran %0d draws, %0d clears, %0d reads, %0d unused words on %0d canvas sizes",
             cmd_count[lrp_pkg::CMD_DRAW], cmd_count[lrp_pkg::CMD_CLEAR],
             cmd_count[lrp_pkg::CMD_READ], cmd_count[lrp_pkg::CMD_NONE], PHASES);
    $display("checked %0d results after %0d register writes, %0d failures",
             results_checked, cfg_writes, fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
